FILE: hw/rtl/ffba_pkg.sv
package ffba_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int OFFSET_BITS  = 16;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

  localparam logic [OFFSET_BITS-1:0] POOL_RESET = 16'hFFFF;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic REG_POOL_SIZE = 1'b0;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_FIT     = 2'd1,
    STAT_TABLE_FULL = 2'd2,
    STAT_NOT_FOUND  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SPLIT,
    ST_FNEXT,
    ST_FPREV,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic idx_inc;
    logic idx_dec;
    logic prev_load;
    logic cur_load;
    logic mark_used;
    logic mark_free;
    logic split;
    logic merge;
    logic merge_prev;
  } dp_cmd_t;

  typedef struct packed {
    logic act_free;
    logic req_zero;
    logic rd_free;
    logic fit;
    logic exact;
    logic match;
    logic last;
    logic full;
    logic first;
    logic prev_free;
  } dp_stat_t;

  typedef struct packed {
    logic    load;
    status_t status;
    logic    use_addr;
  } res_t;

endpackage

FILE: hw/rtl/ffba_ctrl.sv
module ffba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_free,
  input  ffba_pkg::dp_stat_t stat,
  output ffba_pkg::dp_cmd_t  cmd,
  output ffba_pkg::res_t     res
);

  ffba_pkg::state_t  state, state_next;
  ffba_pkg::status_t res_status, res_status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ffba_pkg::ST_IDLE;
      res_status <= ffba_pkg::STAT_OK;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
    end
  end

  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    cmd             = '0;
    in_ready        = 1'b0;
    res.load        = 1'b0;
    res.status      = res_status;
    res.use_addr    = 1'b0;
    unique case (state)
      ffba_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ffba_pkg::ST_SCAN;
        end
      end
      ffba_pkg::ST_SCAN: begin
        if (!stat.act_free) begin
          if (stat.req_zero) begin
            res_status_next = ffba_pkg::STAT_NO_FIT;
            state_next      = ffba_pkg::ST_RESULT;
          end else if (stat.rd_free && stat.fit) begin
            if (stat.exact) begin
              cmd.mark_used   = 1'b1;
              res_status_next = ffba_pkg::STAT_OK;
              state_next      = ffba_pkg::ST_RESULT;
            end else if (stat.full) begin
              res_status_next = ffba_pkg::STAT_TABLE_FULL;
              state_next      = ffba_pkg::ST_RESULT;
            end else begin
              state_next = ffba_pkg::ST_SPLIT;
            end
          end else if (stat.last) begin
            res_status_next = ffba_pkg::STAT_NO_FIT;
            state_next      = ffba_pkg::ST_RESULT;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end else begin
          if (stat.match) begin
            cmd.mark_free   = 1'b1;
            cmd.cur_load    = 1'b1;
            res_status_next = ffba_pkg::STAT_OK;
            if (stat.last) begin
              state_next = ffba_pkg::ST_FPREV;
            end else begin
              cmd.idx_inc = 1'b1;
              state_next  = ffba_pkg::ST_FNEXT;
            end
          end else if (stat.last) begin
            res_status_next = ffba_pkg::STAT_NOT_FOUND;
            state_next      = ffba_pkg::ST_RESULT;
          end else begin
            cmd.idx_inc   = 1'b1;
            cmd.prev_load = 1'b1;
          end
        end
      end
      ffba_pkg::ST_SPLIT: begin
        cmd.split       = 1'b1;
        res_status_next = ffba_pkg::STAT_OK;
        state_next      = ffba_pkg::ST_RESULT;
      end
      ffba_pkg::ST_FNEXT: begin
        cmd.merge   = stat.rd_free;
        cmd.idx_dec = 1'b1;
        state_next  = ffba_pkg::ST_FPREV;
      end
      ffba_pkg::ST_FPREV: begin
        cmd.merge      = !stat.first && stat.prev_free;
        cmd.merge_prev = 1'b1;
        state_next     = ffba_pkg::ST_RESULT;
      end
      ffba_pkg::ST_RESULT: begin
        res.use_addr = !stat.act_free && (res_status == ffba_pkg::STAT_OK);
        if (out_free) begin
          res.load   = 1'b1;
          state_next = ffba_pkg::ST_IDLE;
        end
      end
      default: state_next = ffba_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/ffba_datapath.sv
module ffba_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             init,
  input  logic [ffba_pkg::OFFSET_BITS-1:0] pool_size,
  input  logic                             in_action,
  input  logic [ffba_pkg::OFFSET_BITS-1:0] in_request_size,
  input  logic [ffba_pkg::OFFSET_BITS-1:0] in_free_address,
  input  ffba_pkg::dp_cmd_t                cmd,
  output ffba_pkg::dp_stat_t               stat,
  output logic [ffba_pkg::OFFSET_BITS-1:0] rd_start
);

  logic [ffba_pkg::OFFSET_BITS-1:0] seg_start [ffba_pkg::MAX_SEGMENTS];
  logic [ffba_pkg::OFFSET_BITS-1:0] seg_len   [ffba_pkg::MAX_SEGMENTS];
  logic                             seg_free  [ffba_pkg::MAX_SEGMENTS];

  logic [ffba_pkg::OFFSET_BITS-1:0] up_start   [ffba_pkg::MAX_SEGMENTS];
  logic [ffba_pkg::OFFSET_BITS-1:0] up_len     [ffba_pkg::MAX_SEGMENTS];
  logic                             up_free    [ffba_pkg::MAX_SEGMENTS];
  logic [ffba_pkg::OFFSET_BITS-1:0] down_start [ffba_pkg::MAX_SEGMENTS];
  logic [ffba_pkg::OFFSET_BITS-1:0] down_len   [ffba_pkg::MAX_SEGMENTS];
  logic                             down_free  [ffba_pkg::MAX_SEGMENTS];

  logic [ffba_pkg::IDX_W-1:0]       idx;
  logic [ffba_pkg::CNT_W-1:0]       count;
  logic [ffba_pkg::CNT_W-1:0]       idx_w;
  logic [ffba_pkg::CNT_W-1:0]       idx_w1;
  logic                             act;
  logic [ffba_pkg::OFFSET_BITS-1:0] req;
  logic [ffba_pkg::OFFSET_BITS-1:0] faddr;
  logic [ffba_pkg::OFFSET_BITS-1:0] cur_len;
  logic [ffba_pkg::OFFSET_BITS-1:0] prev_len;
  logic                             prev_free;
  logic [ffba_pkg::OFFSET_BITS-1:0] rd_len;
  logic                             rd_free;
  logic [ffba_pkg::OFFSET_BITS-1:0] split_start;
  logic [ffba_pkg::OFFSET_BITS-1:0] split_len;
  logic [ffba_pkg::OFFSET_BITS-1:0] sum;

  assign rd_start    = seg_start[idx];
  assign rd_len      = seg_len[idx];
  assign rd_free     = seg_free[idx];
  assign idx_w       = {1'b0, idx};
  assign idx_w1      = idx_w + 1'b1;
  assign split_start = rd_start + req;
  assign split_len   = rd_len - req;
  assign sum         = (cmd.merge_prev ? prev_len : rd_len) + cur_len;

  assign stat.act_free  = (act == ffba_pkg::ACT_FREE);
  assign stat.req_zero  = (req == '0);
  assign stat.rd_free   = rd_free;
  assign stat.fit       = (rd_len >= req);
  assign stat.exact     = (rd_len == req);
  assign stat.match     = (rd_start == faddr);
  assign stat.last      = (idx_w1 == count);
  assign stat.full      = (count == ffba_pkg::CNT_W'(ffba_pkg::MAX_SEGMENTS));
  assign stat.first     = (idx == '0);
  assign stat.prev_free = prev_free;

  always_ff @(posedge clk) begin
    if (rst || init) begin
      count <= ffba_pkg::CNT_W'(1);
    end else if (cmd.split) begin
      count <= count + 1'b1;
    end else if (cmd.merge) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.load) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end else if (cmd.idx_dec) begin
      idx <= idx - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act   <= in_action;
      req   <= in_request_size;
      faddr <= in_free_address;
    end
    if (cmd.prev_load) begin
      prev_free <= rd_free;
      prev_len  <= rd_len;
    end
    if (cmd.cur_load) begin
      cur_len <= rd_len;
    end else if (cmd.merge) begin
      cur_len <= sum;
    end
  end

  for (genvar g = 0; g < ffba_pkg::MAX_SEGMENTS; g++) begin : g_entry
    localparam logic [ffba_pkg::CNT_W-1:0] K = ffba_pkg::CNT_W'(g);

    if (g > 0) begin : g_up
      assign up_start[g] = seg_start[g-1];
      assign up_len[g]   = seg_len[g-1];
      assign up_free[g]  = seg_free[g-1];
    end else begin : g_up0
      assign up_start[g] = seg_start[g];
      assign up_len[g]   = seg_len[g];
      assign up_free[g]  = seg_free[g];
    end

    if (g < ffba_pkg::MAX_SEGMENTS - 1) begin : g_down
      assign down_start[g] = seg_start[g+1];
      assign down_len[g]   = seg_len[g+1];
      assign down_free[g]  = seg_free[g+1];
    end else begin : g_down_end
      assign down_start[g] = seg_start[g];
      assign down_len[g]   = seg_len[g];
      assign down_free[g]  = seg_free[g];
    end

    always_ff @(posedge clk) begin
      if (rst || init) begin
        if (g == 0) begin
          seg_start[g] <= '0;
          seg_len[g]   <= rst ? ffba_pkg::POOL_RESET : pool_size;
          seg_free[g]  <= 1'b1;
        end
      end else if (cmd.split) begin
        if (K == idx_w) begin
          seg_len[g]  <= req;
          seg_free[g] <= 1'b0;
        end else if (K == idx_w1) begin
          seg_start[g] <= split_start;
          seg_len[g]   <= split_len;
          seg_free[g]  <= 1'b1;
        end else if (K > idx_w1) begin
          seg_start[g] <= up_start[g];
          seg_len[g]   <= up_len[g];
          seg_free[g]  <= up_free[g];
        end
      end else if (cmd.mark_used) begin
        if (K == idx_w) seg_free[g] <= 1'b0;
      end else if (cmd.mark_free) begin
        if (K == idx_w) seg_free[g] <= 1'b1;
      end else if (cmd.merge) begin
        if (ffba_pkg::CNT_W'(K + 1'b1) == idx_w) begin
          seg_len[g] <= sum;
        end else if (K >= idx_w) begin
          seg_start[g] <= down_start[g];
          seg_len[g]   <= down_len[g];
          seg_free[g]  <= down_free[g];
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != '0 && count <= ffba_pkg::CNT_W'(ffba_pkg::MAX_SEGMENTS))
    else $error("segment count out of range");

  a_split_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.split |-> !stat.full && rd_free && rd_len > req)
    else $error("split of an unfit or full table");

  a_merge_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.merge |-> idx != '0 && count > ffba_pkg::CNT_W'(1))
    else $error("merge without a previous entry");

  a_split_grow: assert property (@(posedge clk) disable iff (rst)
    cmd.split |=> count == ffba_pkg::CNT_W'($past(count) + 1'b1))
    else $error("split did not grow the table");
`endif

endmodule

FILE: hw/rtl/first_fit_block_allocator.sv
// First-fit segment allocator with coalescing over a pool of pool_size bytes. Each input word
// is an allocate (tuser 0, size in request_size) or a free (tuser 1, start in free_address), and
// yields one result word with a status and, for a successful allocate, the segment start. The
// table scan reads one segment entry per cycle and stops at the first free entry that fits (at
// once for a zero size), at the entry that a free names, or at the last entry. An allocate that
// splits then passes through a split step, and a free that finds its segment checks the next
// neighbor (skipped for the last entry) and then the previous one for merging; the result then
// waits until the output register is free. Inserts and removals shift the following table
// entries all at once. The table is ready right after reset with no clearing pass; writing
// pool_size restarts it as one free segment and must only happen while the block is idle. A
// finished result sits in the output register while the next word is accepted.
module first_fit_block_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // request_size[15:0], free_address[31:16]
  input  logic        s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // status[1:0], address[17:2], zero[23:18]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [ffba_pkg::OFFSET_BITS-1:0] pool_size;
  logic                             cfg_wr;
  logic                             out_free;
  logic [ffba_pkg::OFFSET_BITS-1:0] rd_start;
  ffba_pkg::status_t                m_status;
  logic [ffba_pkg::OFFSET_BITS-1:0] m_address;
  ffba_pkg::dp_cmd_t                cmd;
  ffba_pkg::dp_stat_t               stat;
  ffba_pkg::res_t                   res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == ffba_pkg::REG_POOL_SIZE);
  assign prdata = (paddr[2] == ffba_pkg::REG_POOL_SIZE) ? {16'd0, pool_size} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size <= ffba_pkg::POOL_RESET;
    end else if (cfg_wr) begin
      pool_size <= pwdata[15:0];
    end
  end

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      m_status  <= res.status;
      m_address <= res.use_addr ? rd_start : '0;
    end
  end

  assign m_tdata = {6'd0, m_address, m_status};

  ffba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd),
    .res      (res)
  );

  ffba_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .init            (cfg_wr),
    .pool_size       (pwdata[15:0]),
    .in_action       (s_tuser),
    .in_request_size (s_tdata[15:0]),
    .in_free_address (s_tdata[31:16]),
    .cmd             (cmd),
    .stat            (stat),
    .rd_start        (rd_start)
  );

endmodule
